// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the clock block.
// Include by bare file name; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/clk24_pkg.sv =====
// Package for the 24-hour clock block: result type, register map,
// reset values and seven-segment decode. No dependencies.
`timescale 1ns / 1ps

package clk24_pkg;

  localparam int unsigned CfgWidth = 6;

  // Register indexes on the APB port (byte address = 4 * index)
  localparam logic REG_ALARM_PERIOD   = 1'b0;
  localparam logic REG_ALARM_DURATION = 1'b1;

  localparam logic [CfgWidth-1:0] ALARM_PERIOD_RST   = 6'd2;
  localparam logic [CfgWidth-1:0] ALARM_DURATION_RST = 6'd5;

  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic       in_set_mode;
    logic       setting_hours;
    logic       buzzer_on;
    logic [7:0] hour_tens_seg;
    logic [7:0] hour_units_seg;
    logic [7:0] minute_tens_seg;
    logic [7:0] minute_units_seg;
  } result_t;

  // Active-low segment pattern for one decimal digit
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h80;
      4'd1:    seg = 8'hF1;
      4'd2:    seg = 8'h44;
      4'd3:    seg = 8'h60;
      4'd4:    seg = 8'h31;
      4'd5:    seg = 8'h22;
      4'd6:    seg = 8'h02;
      4'd7:    seg = 8'hF0;
      4'd8:    seg = 8'h00;
      4'd9:    seg = 8'h20;
      default: seg = 8'hFF;
    endcase
    return seg;
  endfunction

  // Tens digit of a value below 64, by a short compare chain
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 6; k++) begin
      if (v >= 6'(10 * k)) t = 4'(k);
    end
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] r;
    r = v - ({2'b00, tens_of(v)} * 6'd10);
    return r[3:0];
  endfunction

endpackage

// ===== rtl/core/clock_24h_set_mode_alarm.sv =====
// 24-hour clock with set mode, periodic buzzer and seven-segment decode.
// Depends on clk24_pkg.
//
// Usage:
//   Input channel (item_valid / item_stall): one beat per control-loop pass,
//   carrying second_tick and the debounced button presses.
//   Result channel (result_valid / result_stall): one beat per input beat,
//   with the time, mode bits, buzzer level and four active-low digit patterns.
//   APB port: alarm_period at 0x0, alarm_duration at 0x4 (6 bits each);
//   write only while the block is idle.
// Results: each accepted beat is registered into the output register or the skid entry.
// Throughput: one beat per cycle while item_stall is low; the clock state updates
//   in a single registered pass at the accept edge.
// Stalls: a two-entry result buffer (output register plus skid) lets one more
//   beat in while a result waits; item_stall rises only when both are full.
// Reset: clock at 00:00:00, set mode with minutes selected, buzzer off,
//   alarm_period 2, alarm_duration 5, both buffer entries empty.
`timescale 1ns / 1ps

module clock_24h_set_mode_alarm (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        second_tick,
  input  logic        mode_press,
  input  logic        field_press,
  input  logic        up_press,
  input  logic        down_press,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [4:0]  hours,
  output logic [5:0]  minutes,
  output logic        in_set_mode,
  output logic        setting_hours,
  output logic        buzzer_on,
  output logic [7:0]  hour_tens_seg,
  output logic [7:0]  hour_units_seg,
  output logic [7:0]  minute_tens_seg,
  output logic [7:0]  minute_units_seg,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [5:0] alarm_period;
  logic [5:0] alarm_duration;

  // clock state; the alarm second count always equals second_count
  // (same reset, same tick, same rollover), so one register serves both
  logic [5:0] second_count, second_count_next;
  logic [5:0] minute_count, minute_count_next;
  logic [4:0] hour_count, hour_count_next;
  logic [5:0] alarm_minute_count, alarm_minute_count_next;
  logic       setting, setting_next;
  logic       field_is_hours, field_is_hours_next;
  logic       buzzer, buzzer_next;

  clk24_pkg::result_t res_next, out_q, skid_q;
  logic skid_valid;
  logic accept, take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == clk24_pkg::REG_ALARM_DURATION) ?
                  {26'd0, alarm_duration} : {26'd0, alarm_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_period   <= clk24_pkg::ALARM_PERIOD_RST;
      alarm_duration <= clk24_pkg::ALARM_DURATION_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == clk24_pkg::REG_ALARM_PERIOD) begin
        alarm_period <= pwdata[5:0];
      end else begin
        alarm_duration <= pwdata[5:0];
      end
    end
  end

  assign accept = item_valid && !skid_valid;
  assign take   = result_valid && !result_stall;
  assign item_stall = skid_valid;

  // single pass of the control loop
  always_comb begin
    logic [5:0] sec_inc;
    logic [5:0] am_inc;
    logic       sec_roll;
    logic       min_roll;

    second_count_next       = second_count;
    minute_count_next       = minute_count;
    hour_count_next         = hour_count;
    alarm_minute_count_next = alarm_minute_count;
    setting_next            = setting;
    field_is_hours_next     = field_is_hours;
    buzzer_next             = buzzer;
    sec_inc  = second_count + 6'(second_tick);
    sec_roll = sec_inc > clk24_pkg::SEC_MAX;
    min_roll = 1'b0;
    am_inc   = alarm_minute_count;

    if (mode_press) begin
      setting_next = !setting;
      if (!setting) field_is_hours_next = 1'b0;
    end
    if (setting_next && field_press) field_is_hours_next = !field_is_hours_next;

    if (setting_next) begin
      buzzer_next = 1'b0;
      if (field_is_hours_next) begin
        if (up_press) begin
          hour_count_next = (hour_count >= clk24_pkg::HOUR_MAX) ? 5'd0 : hour_count + 5'd1;
        end else if (down_press) begin
          hour_count_next = (hour_count == 5'd0) ? clk24_pkg::HOUR_MAX : hour_count - 5'd1;
        end
      end else begin
        if (up_press) begin
          minute_count_next = (minute_count >= clk24_pkg::MIN_MAX) ? 6'd0
                                                                   : minute_count + 6'd1;
        end else if (down_press) begin
          minute_count_next = (minute_count == 6'd0) ? clk24_pkg::MIN_MAX
                                                     : minute_count - 6'd1;
        end
      end
    end else begin
      second_count_next = sec_roll ? 6'd0 : sec_inc;
      if (sec_roll) begin
        am_inc   = alarm_minute_count + 6'd1;
        min_roll = minute_count >= clk24_pkg::MIN_MAX;
        minute_count_next = min_roll ? 6'd0 : minute_count + 6'd1;
      end
      if (min_roll) begin
        hour_count_next = (hour_count >= clk24_pkg::HOUR_MAX) ? 5'd0 : hour_count + 5'd1;
      end
      alarm_minute_count_next = am_inc;
      if (am_inc >= alarm_period) begin
        buzzer_next             = 1'b1;
        alarm_minute_count_next = 6'd0;
      end
      // turn-off is applied after turn-on, so it wins in the same pass
      if (second_count_next == alarm_duration) buzzer_next = 1'b0;
    end

    res_next.hours            = hour_count_next;
    res_next.minutes          = minute_count_next;
    res_next.in_set_mode      = setting_next;
    res_next.setting_hours    = field_is_hours_next;
    res_next.buzzer_on        = buzzer_next;
    res_next.hour_tens_seg    = clk24_pkg::seg_of(clk24_pkg::tens_of({1'b0, hour_count_next}));
    res_next.hour_units_seg   = clk24_pkg::seg_of(clk24_pkg::units_of({1'b0, hour_count_next}));
    res_next.minute_tens_seg  = clk24_pkg::seg_of(clk24_pkg::tens_of(minute_count_next));
    res_next.minute_units_seg = clk24_pkg::seg_of(clk24_pkg::units_of(minute_count_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_count       <= 6'd0;
      minute_count       <= 6'd0;
      hour_count         <= 5'd0;
      alarm_minute_count <= 6'd0;
      setting            <= 1'b1;
      field_is_hours     <= 1'b0;
      buzzer             <= 1'b0;
    end else if (accept) begin
      second_count       <= second_count_next;
      minute_count       <= minute_count_next;
      hour_count         <= hour_count_next;
      alarm_minute_count <= alarm_minute_count_next;
      setting            <= setting_next;
      field_is_hours     <= field_is_hours_next;
      buzzer             <= buzzer_next;
    end
  end

  // result buffer control: output register first, skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (!result_valid || take) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_next;
      end
    end else if (accept) begin
      skid_q <= res_next;
    end
  end

  assign hours            = out_q.hours;
  assign minutes          = out_q.minutes;
  assign in_set_mode      = out_q.in_set_mode;
  assign setting_hours    = out_q.setting_hours;
  assign buzzer_on        = out_q.buzzer_on;
  assign hour_tens_seg    = out_q.hour_tens_seg;
  assign hour_units_seg   = out_q.hour_units_seg;
  assign minute_tens_seg  = out_q.minute_tens_seg;
  assign minute_units_seg = out_q.minute_units_seg;

endmodule

// ===== rtl/core/clk24_checker.sv =====
// Port-level checker for the 24-hour clock block, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clk24_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [4:0] hours,
  input logic [5:0] minutes,
  input logic       in_set_mode,
  input logic       buzzer_on
);

  // input can only back up when a result is already waiting
  `ASSERT_SAME(a_stall_needs_result, clk, rst, item_stall, result_valid,
               "item stalled with no result")

  // after an accepted beat, result_valid is high on the next cycle
  `ASSERT_NEXT(a_accept_gives_result, clk, rst, item_valid && !item_stall, result_valid,
               "accepted beat lost")

  `ASSERT_NEXT(a_result_holds, clk, rst, result_valid && result_stall,
               result_valid && $stable(hours) && $stable(minutes), "stalled result changed")

  `ASSERT_SAME(a_time_range, clk, rst, result_valid, hours <= 5'd23 && minutes <= 6'd59,
               "time out of range")

  // buzzer is forced off while setting the time
  `ASSERT_SAME(a_setting_quiet, clk, rst, result_valid && in_set_mode, !buzzer_on,
               "buzzer on in set mode")

endmodule

bind clock_24h_set_mode_alarm clk24_checker u_clk24_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .hours        (hours),
  .minutes      (minutes),
  .in_set_mode  (in_set_mode),
  .buzzer_on    (buzzer_on)
);

// ===== bench/tb_clock_24h_set_mode_alarm.sv =====
// Testbench for clock_24h_set_mode_alarm: directed button and mode checks, then
// random set/run sequences under several alarm settings, with stalls and a long hold.
// Depends on clk24_pkg and the clock_24h_set_mode_alarm RTL.
`timescale 1ns / 1ps

module tb_clock_24h_set_mode_alarm;

  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int IDLE_PCT    = 23;

  localparam logic [7:0] DIGIT_SEG [10] = '{
    8'h80, 8'hF1, 8'h44, 8'h60, 8'h31, 8'h22, 8'h02, 8'hF0, 8'h00, 8'h20
  };

  typedef struct packed {
    logic tick;
    logic mode;
    logic field;
    logic up;
    logic down;
  } press_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic        second_tick;
  logic        mode_press;
  logic        field_press;
  logic        up_press;
  logic        down_press;
  logic        result_valid;
  logic        result_stall;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic        in_set_mode;
  logic        setting_hours;
  logic        buzzer_on;
  logic [7:0]  hour_tens_seg;
  logic [7:0]  hour_units_seg;
  logic [7:0]  minute_tens_seg;
  logic [7:0]  minute_units_seg;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  clock_24h_set_mode_alarm dut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .second_tick      (second_tick),
    .mode_press       (mode_press),
    .field_press      (field_press),
    .up_press         (up_press),
    .down_press       (down_press),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .hours            (hours),
    .minutes          (minutes),
    .in_set_mode      (in_set_mode),
    .setting_hours    (setting_hours),
    .buzzer_on        (buzzer_on),
    .hour_tens_seg    (hour_tens_seg),
    .hour_units_seg   (hour_units_seg),
    .minute_tens_seg  (minute_tens_seg),
    .minute_units_seg (minute_units_seg),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Predicted clock state and alarm settings
  logic [5:0] clk_sec;
  logic [5:0] clk_min;
  logic [4:0] clk_hr;
  logic [5:0] alm_min;
  logic [5:0] alm_sec;
  logic       setting_now;
  logic       hours_sel;
  logic       buzz;
  logic [5:0] cfg_period;
  logic [5:0] cfg_duration;

  clk24_pkg::result_t expected_readings[$];
  int      mismatch_count = 0;
  int      beats_sent = 0;
  int      quiet_cycles = 0;
  int      hold_req = 0;
  int      hold_seen = 0;
  logic    stall_on;
  bit      idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic clk24_pkg::result_t advance_clock(press_t p);
    clk24_pkg::result_t r;
    if (p.mode) begin
      if (setting_now) begin
        setting_now = 1'b0;
      end else begin
        setting_now = 1'b1;
        hours_sel   = 1'b0;
      end
    end
    // a field press in the entering pass still counts
    if (setting_now && p.field) hours_sel = !hours_sel;

    if (setting_now) begin
      buzz = 1'b0;
      if (hours_sel) begin
        if (p.up) clk_hr = (clk_hr >= clk24_pkg::HOUR_MAX) ? 5'd0 : clk_hr + 5'd1;
        else if (p.down) clk_hr = (clk_hr == 5'd0) ? clk24_pkg::HOUR_MAX : clk_hr - 5'd1;
      end else begin
        if (p.up) clk_min = (clk_min >= clk24_pkg::MIN_MAX) ? 6'd0 : clk_min + 6'd1;
        else if (p.down) clk_min = (clk_min == 6'd0) ? clk24_pkg::MIN_MAX : clk_min - 6'd1;
      end
    end else begin
      if (p.tick) begin
        clk_sec = clk_sec + 6'd1;
        alm_sec = alm_sec + 6'd1;
      end
      if (clk_sec > clk24_pkg::SEC_MAX) begin
        clk_sec = 6'd0;
        alm_sec = 6'd0;
        alm_min = alm_min + 6'd1;
        clk_min = clk_min + 6'd1;
      end
      if (clk_min > clk24_pkg::MIN_MAX) begin
        clk_min = 6'd0;
        clk_hr  = clk_hr + 5'd1;
      end
      if (clk_hr > clk24_pkg::HOUR_MAX) clk_hr = 5'd0;
      if (alm_min >= cfg_period) begin
        buzz    = 1'b1;
        alm_min = 6'd0;
      end
      // turn-off is tested after turn-on, so it wins
      if (alm_sec == cfg_duration) buzz = 1'b0;
    end

    r.hours            = clk_hr;
    r.minutes          = clk_min;
    r.in_set_mode      = setting_now;
    r.setting_hours    = hours_sel;
    r.buzzer_on        = buzz;
    r.hour_tens_seg    = DIGIT_SEG[clk_hr / 10];
    r.hour_units_seg   = DIGIT_SEG[clk_hr % 10];
    r.minute_tens_seg  = DIGIT_SEG[clk_min / 10];
    r.minute_units_seg = DIGIT_SEG[clk_min % 10];
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v)
      note_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got_v, want_v));
  endtask

  // Send one beat; returns in the step of the accepting edge with valid still high
  task automatic send_beat(input press_t p);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid  <= 1'b1;
    second_tick <= p.tick;
    mode_press  <= p.mode;
    field_press <= p.field;
    up_press    <= p.up;
    down_press  <= p.down;
    do @(posedge clk); while (item_stall);
    expected_readings.push_back(advance_clock(p));
    beats_sent++;
  endtask

  task automatic wait_results_done;
    item_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one alarm register, then read it back
  task automatic write_alarm_reg(input logic idx, input logic [5:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {26'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == clk24_pkg::REG_ALARM_PERIOD) cfg_period = val;
    else cfg_duration = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[5:0] !== val)
      note_mismatch($sformatf("readback of reg %0d got 0x%0h, want 0x%0h", idx, rd, val));
  endtask

  // Step the selected field to target the short way round
  task automatic step_to(input int target, input int span);
    press_t p;
    int cur;
    int fwd;
    forever begin
      cur = hours_sel ? int'(clk_hr) : int'(clk_min);
      if (cur == target) break;
      fwd = (target - cur + span) % span;
      p = '0;
      p.tick = 1'($urandom_range(1));
      if (fwd <= span / 2) begin
        p.up   = 1'b1;
        p.down = ($urandom_range(3) == 0);
      end else begin
        p.down = 1'b1;
      end
      send_beat(p);
    end
  endtask

  task automatic set_time_sequence;
    press_t p;
    int want_min;
    int want_hr;
    want_min = ($urandom_range(3) == 0) ? $urandom_range(0, 59) : $urandom_range(57, 59);
    want_hr  = ($urandom_range(1) == 0) ? $urandom_range(0, 23) : 23;
    if (!setting_now) begin
      p = '0;
      p.mode  = 1'b1;
      p.tick  = 1'($urandom_range(1));
      p.field = 1'($urandom_range(1));
      send_beat(p);
    end
    repeat (2) begin
      if (hours_sel) step_to(want_hr, 24);
      else step_to(want_min, 60);
      p = '0;
      p.field = 1'b1;
      p.tick  = 1'($urandom_range(1));
      send_beat(p);
    end
    // leave set mode; other buttons are don't-care in this beat
    p = press_t'(5'($urandom));
    p.mode = 1'b1;
    send_beat(p);
  endtask

  task automatic run_sequence;
    press_t p;
    int len;
    len = $urandom_range(20, 120);
    if (setting_now) begin
      p = '0;
      p.mode = 1'b1;
      p.tick = 1'($urandom_range(1));
      send_beat(p);
    end
    repeat (len) begin
      p.tick  = ($urandom_range(99) < 85);
      p.mode  = 1'b0;
      p.field = ($urandom_range(9) == 0);
      p.up    = ($urandom_range(9) == 0);
      p.down  = ($urandom_range(9) == 0);
      send_beat(p);
    end
  endtask

  task automatic random_phase(input int n);
    int start;
    int kind;
    start = beats_sent;
    while (beats_sent - start < n) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        set_time_sequence();
      end else if (kind < 85) begin
        run_sequence();
      end else begin
        repeat ($urandom_range(1, 4)) send_beat(press_t'(5'($urandom)));
      end
    end
  endtask

  task automatic test_setting_buttons;
    // bit order: tick, mode, field, up, down
    send_beat(press_t'(5'b00000));  // idle in set mode
    send_beat(press_t'(5'b00001));  // minutes wrap down to 59
    send_beat(press_t'(5'b00010));  // and back up to 0
    send_beat(press_t'(5'b00011));  // up beats down
    send_beat(press_t'(5'b10000));  // tick ignored while setting
    send_beat(press_t'(5'b00100));  // select hours
    send_beat(press_t'(5'b00001));  // hours wrap down to 23
    send_beat(press_t'(5'b00010));
    send_beat(press_t'(5'b00011));
    send_beat(press_t'(5'b00001));
    send_beat(press_t'(5'b00110));  // back to minutes, then step
    send_beat(press_t'(5'b01100));  // leave set mode, field press dropped
    send_beat(press_t'(5'b10000));
    send_beat(press_t'(5'b10011));  // buttons ignored while running
    send_beat(press_t'(5'b10100));
    send_beat(press_t'(5'b01100));  // enter set mode, field press takes effect
    send_beat(press_t'(5'b00010));
    send_beat(press_t'(5'b11111));  // leave, the tick runs
    send_beat(press_t'(5'b00000));
    send_beat(press_t'(5'b01000));
    send_beat(press_t'(5'b01010));  // leave again, up dropped
    wait_results_done();
  endtask

  task automatic test_alarm_settings;
    logic [5:0] periods   [6] = '{6'd60, 6'd1, 6'd0, 6'd63, 6'd1, 6'd2};
    logic [5:0] durations [6] = '{6'd59, 6'd1, 6'd0, 6'd63, 6'd0, 6'd5};
    for (int i = 0; i < 6; i++) begin
      write_alarm_reg(clk24_pkg::REG_ALARM_PERIOD, periods[i]);
      write_alarm_reg(clk24_pkg::REG_ALARM_DURATION, durations[i]);
      random_phase(150);
      wait_results_done();
    end
  endtask

  task automatic test_steady_stream;
    write_alarm_reg(clk24_pkg::REG_ALARM_PERIOD, 6'($urandom_range(0, 63)));
    write_alarm_reg(clk24_pkg::REG_ALARM_DURATION, 6'($urandom_range(0, 63)));
    idle_on = 1'b0;
    stall_on <= 1'b0;
    random_phase(200);
    wait_results_done();
    idle_on = 1'b1;
    stall_on <= 1'b1;
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_output_hold;
    hold_req <= hold_req + 1;
    random_phase(40);
    wait_results_done();
  endtask

  // Result sink: random stall, plus a long hold on request
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= stall_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    clk24_pkg::result_t got;
    clk24_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {hours, minutes, in_set_mode, setting_hours, buzzer_on,
             hour_tens_seg, hour_units_seg, minute_tens_seg, minute_units_seg};
      if (expected_readings.size() == 0) begin
        note_mismatch("result beat with nothing expected");
      end else begin
        want = expected_readings.pop_front();
        check_field("hours", 8'(got.hours), 8'(want.hours));
        check_field("minutes", 8'(got.minutes), 8'(want.minutes));
        check_field("in_set_mode", 8'(got.in_set_mode), 8'(want.in_set_mode));
        check_field("setting_hours", 8'(got.setting_hours), 8'(want.setting_hours));
        check_field("buzzer_on", 8'(got.buzzer_on), 8'(want.buzzer_on));
        check_field("hour_tens_seg", got.hour_tens_seg, want.hour_tens_seg);
        check_field("hour_units_seg", got.hour_units_seg, want.hour_units_seg);
        check_field("minute_tens_seg", got.minute_tens_seg, want.minute_tens_seg);
        check_field("minute_units_seg", got.minute_units_seg, want.minute_units_seg);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst         <= 1'b1;
    item_valid  <= 1'b0;
    second_tick <= 1'b0;
    mode_press  <= 1'b0;
    field_press <= 1'b0;
    up_press    <= 1'b0;
    down_press  <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    stall_on    <= 1'b1;

    clk_sec      = 6'd0;
    clk_min      = 6'd0;
    clk_hr       = 5'd0;
    alm_min      = 6'd0;
    alm_sec      = 6'd0;
    setting_now  = 1'b1;
    hours_sel    = 1'b0;
    buzz         = 1'b0;
    cfg_period   = clk24_pkg::ALARM_PERIOD_RST;
    cfg_duration = clk24_pkg::ALARM_DURATION_RST;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_setting_buttons();
    test_alarm_settings();
    test_output_hold();
    test_steady_stream();

    wait_results_done();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
